@@ hw/rtl/bprs_pkg.sv @@
// bprs_pkg: shared types and constants for the bitmap pixel store rotator.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package bprs_pkg;

  localparam int DEFAULT_MAX_DIM = 128;

  // Field widths of the channels and the configuration port
  localparam int MODE_W     = 2;
  localparam int POS_W      = 7;
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_LEFT  = 2'd2,
    MODE_RIGHT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_TURN,
    ST_TDONE
  } state_t;

endpackage

@@ hw/rtl/bprs_if.sv @@
// bprs_if: valid/ready channel interfaces for the pixel command and result streams.
// Depends on bprs_pkg for field widths.
`timescale 1ns / 1ps

interface bprs_in_if;
  logic                        valid;
  logic                        ready;
  logic [bprs_pkg::MODE_W-1:0] mode;
  logic [bprs_pkg::POS_W-1:0]  pos_x;
  logic [bprs_pkg::POS_W-1:0]  pos_y;
  logic [bprs_pkg::PIX_W-1:0]  colour;

  modport source (output valid, mode, pos_x, pos_y, colour, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, colour, output ready);
endinterface

interface bprs_out_if;
  logic                       valid;
  logic                       ready;
  logic [bprs_pkg::PIX_W-1:0] pixel_value;
  logic                       status;
  logic [bprs_pkg::DIM_W-1:0] cur_width;
  logic [bprs_pkg::DIM_W-1:0] cur_height;

  modport source (output valid, pixel_value, status, cur_width, cur_height, input ready);
  modport sink   (input valid, pixel_value, status, cur_width, cur_height, output ready);
endinterface

@@ hw/rtl/bprs_bank.sv @@
// bprs_bank: one frame store bank, simple dual port RAM with registered read.
// Depends on bprs_pkg for the pixel width and default dimension.
`timescale 1ns / 1ps

module bprs_bank #(
  parameter int MAX_DIM = bprs_pkg::DEFAULT_MAX_DIM
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     waddr,
  input  logic [bprs_pkg::PIX_W-1:0]             wdata,
  input  logic                                   re,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     raddr,
  output logic [bprs_pkg::PIX_W-1:0]             rdata
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [bprs_pkg::PIX_W-1:0] mem [DEPTH];
  logic [bprs_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bprs_ctrl.sv @@
// bprs_ctrl: command sequencer, configuration registers, clear sweep and turn walker.
// Depends on bprs_pkg and bprs_if; drives the ports of both bprs_bank instances.
`timescale 1ns / 1ps

module bprs_ctrl #(
  parameter int MAX_DIM = bprs_pkg::DEFAULT_MAX_DIM
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  bprs_in_if.sink                              in_chan,
  bprs_out_if.source                           out_chan,
  input  logic                                 cfg_we,
  input  logic [bprs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bprs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 a_we,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_waddr,
  output logic [bprs_pkg::PIX_W-1:0]           a_wdata,
  output logic                                 a_re,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_raddr,
  input  logic [bprs_pkg::PIX_W-1:0]           a_rdata,
  output logic                                 b_we,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_waddr,
  output logic [bprs_pkg::PIX_W-1:0]           b_wdata,
  output logic                                 b_re,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_raddr,
  input  logic [bprs_pkg::PIX_W-1:0]           b_rdata
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_DIM);
  localparam int PW    = bprs_pkg::PIX_W;
  localparam int DW    = bprs_pkg::DIM_W;

  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_DIM);
  localparam logic [AW-1:0] CLR_LAST   = AW'(DEPTH - 1);
  localparam logic [DW-1:0] DIM_RST    =
    (int'(bprs_pkg::DIM_RESET) > MAX_DIM) ? DW'(MAX_DIM) : bprs_pkg::DIM_RESET;

  function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y);
    pix_addr = AW'(y) * ROW_STRIDE + AW'(x);
  endfunction

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
    if (v == '0) begin
      clamp_dim = DW'(1);
    end else if (32'(v) > MAX_DIM) begin
      clamp_dim = DW'(MAX_DIM);
    end else begin
      clamp_dim = v;
    end
  endfunction

  bprs_pkg::state_t state_r, state_nxt;

  logic            depth_r;
  logic [DW-1:0]   cfg_w_r, cfg_h_r;
  logic [DW-1:0]   width_r, height_r;
  logic            active_r;
  logic [AW-1:0]   clr_cnt_r;
  logic [CW-1:0]   ox_r, oy_r;
  logic            turn_right_r;
  logic            wr_pend_r;
  logic [AW-1:0]   wr_addr_r;
  logic            out_valid_r;
  logic [PW-1:0]   out_pix_r;
  logic            out_status_r;

  // Decoded command
  bprs_pkg::mode_t in_mode;
  logic            in_acc;
  logic            in_range;
  logic            is_pixel_op;
  logic [AW-1:0]   in_addr;
  logic [PW-1:0]   in_wdata;

  // Config decode
  logic            cfg_hit;
  logic            dep_nxt;
  logic [DW-1:0]   cw_nxt, ch_nxt;

  // Turn walker
  logic [CW-1:0]   last_x, last_y;
  logic [CW-1:0]   nx, ny;
  logic            row_last, turn_last;
  logic            clr_done;

  logic [PW-1:0]   rd_src;
  logic            load_out;

  // Ports seen from the active bank and the other bank
  logic            act_we, act_re, oth_we, oth_re;
  logic [AW-1:0]   act_waddr, act_raddr, oth_waddr, oth_raddr;
  logic [PW-1:0]   act_wdata, oth_wdata;

  assign in_mode     = bprs_pkg::mode_t'(in_chan.mode);
  assign in_acc      = in_chan.valid && in_chan.ready;
  assign in_range    = ({1'b0, in_chan.pos_x} < width_r) && ({1'b0, in_chan.pos_y} < height_r);
  assign is_pixel_op = (in_mode == bprs_pkg::MODE_WRITE) || (in_mode == bprs_pkg::MODE_READ);
  assign in_addr     = pix_addr(CW'(in_chan.pos_x), CW'(in_chan.pos_y));
  assign in_wdata    = depth_r ? in_chan.colour : PW'(in_chan.colour != '0);

  always_comb begin
    cfg_hit = cfg_we && (cfg_index inside {bprs_pkg::CFG_DEPTH_MODE,
                                           bprs_pkg::CFG_IMAGE_WIDTH,
                                           bprs_pkg::CFG_IMAGE_HEIGHT});
    dep_nxt = depth_r;
    cw_nxt  = cfg_w_r;
    ch_nxt  = cfg_h_r;
    case (cfg_index)
      bprs_pkg::CFG_DEPTH_MODE:   dep_nxt = cfg_wdata[0];
      bprs_pkg::CFG_IMAGE_WIDTH:  cw_nxt  = cfg_wdata;
      bprs_pkg::CFG_IMAGE_HEIGHT: ch_nxt  = cfg_wdata;
      default: ;
    endcase
  end

  assign last_x    = CW'(width_r - DW'(1));
  assign last_y    = CW'(height_r - DW'(1));
  assign nx        = turn_right_r ? (last_y - oy_r) : oy_r;
  assign ny        = turn_right_r ? ox_r : (last_x - ox_r);
  assign row_last  = (ox_r == last_x);
  assign turn_last = row_last && (oy_r == last_y);
  assign clr_done  = (clr_cnt_r == CLR_LAST);

  assign rd_src    = active_r ? b_rdata : a_rdata;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bprs_pkg::ST_CLEAR: begin
        if (clr_done) state_nxt = bprs_pkg::ST_IDLE;
      end
      bprs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!is_pixel_op) begin
            state_nxt = bprs_pkg::ST_TURN;
          end else if (in_mode == bprs_pkg::MODE_READ && in_range) begin
            state_nxt = bprs_pkg::ST_READ;
          end
        end
      end
      bprs_pkg::ST_READ:  state_nxt = bprs_pkg::ST_IDLE;
      bprs_pkg::ST_TURN: begin
        if (turn_last) state_nxt = bprs_pkg::ST_TDONE;
      end
      bprs_pkg::ST_TDONE: state_nxt = bprs_pkg::ST_IDLE;
      default:            state_nxt = bprs_pkg::ST_CLEAR;
    endcase
    if (cfg_hit) state_nxt = bprs_pkg::ST_CLEAR;
  end

  // Outputs: handshake and bank ports
  always_comb begin
    in_chan.ready = (state_r == bprs_pkg::ST_IDLE) && (!out_valid_r || out_chan.ready);
    act_we    = 1'b0;
    act_waddr = in_addr;
    act_wdata = in_wdata;
    act_re    = 1'b0;
    act_raddr = in_addr;
    oth_we    = wr_pend_r;
    oth_waddr = wr_addr_r;
    oth_wdata = rd_src;
    oth_re    = 1'b0;
    oth_raddr = wr_addr_r;
    load_out  = 1'b0;
    case (state_r)
      bprs_pkg::ST_CLEAR: begin
        act_we    = 1'b1;
        act_waddr = clr_cnt_r;
        act_wdata = '0;
      end
      bprs_pkg::ST_IDLE: begin
        if (in_acc && is_pixel_op) begin
          act_we   = in_range && (in_mode == bprs_pkg::MODE_WRITE);
          act_re   = in_range && (in_mode == bprs_pkg::MODE_READ);
          load_out = !(in_range && (in_mode == bprs_pkg::MODE_READ));
        end
      end
      bprs_pkg::ST_READ:  load_out = 1'b1;
      bprs_pkg::ST_TURN: begin
        act_re    = 1'b1;
        act_raddr = pix_addr(ox_r, oy_r);
      end
      bprs_pkg::ST_TDONE: load_out = 1'b1;
      default: ;
    endcase
  end

  assign a_we    = active_r ? oth_we    : act_we;
  assign a_waddr = active_r ? oth_waddr : act_waddr;
  assign a_wdata = active_r ? oth_wdata : act_wdata;
  assign a_re    = active_r ? oth_re    : act_re;
  assign a_raddr = active_r ? oth_raddr : act_raddr;
  assign b_we    = active_r ? act_we    : oth_we;
  assign b_waddr = active_r ? act_waddr : oth_waddr;
  assign b_wdata = active_r ? act_wdata : oth_wdata;
  assign b_re    = active_r ? act_re    : oth_re;
  assign b_raddr = active_r ? act_raddr : oth_raddr;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bprs_pkg::ST_CLEAR;
      depth_r     <= 1'b0;
      cfg_w_r     <= bprs_pkg::DIM_RESET;
      cfg_h_r     <= bprs_pkg::DIM_RESET;
      width_r     <= DIM_RST;
      height_r    <= DIM_RST;
      active_r    <= 1'b0;
      clr_cnt_r   <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_pend_r <= (state_r == bprs_pkg::ST_TURN) && !cfg_hit;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        depth_r   <= dep_nxt;
        cfg_w_r   <= cw_nxt;
        cfg_h_r   <= ch_nxt;
        width_r   <= clamp_dim(cw_nxt);
        height_r  <= clamp_dim(ch_nxt);
        active_r  <= 1'b0;
        clr_cnt_r <= '0;
      end else begin
        if (state_r == bprs_pkg::ST_CLEAR) begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
        end
        if (state_r == bprs_pkg::ST_TDONE) begin
          active_r <= !active_r;
          width_r  <= height_r;
          height_r <= width_r;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ox_r         <= '0;
      oy_r         <= '0;
      turn_right_r <= (in_mode == bprs_pkg::MODE_RIGHT);
    end else if (state_r == bprs_pkg::ST_TURN) begin
      ox_r <= row_last ? '0 : ox_r + CW'(1);
      if (row_last) oy_r <= oy_r + CW'(1);
    end
    // destination of the pixel being read; written when its data returns
    wr_addr_r <= pix_addr(nx, ny);
    if (load_out) begin
      out_pix_r    <= (state_r == bprs_pkg::ST_READ) ? rd_src : '0;
      out_status_r <= (state_r == bprs_pkg::ST_IDLE) && !in_range;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_value = out_pix_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.cur_width   = width_r;
  assign out_chan.cur_height  = height_r;

`ifndef SYNTHESIS
  a_one_write_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(act_we && oth_we))
    else $error("active and other bank written in the same cycle");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bprs_pkg::ST_CLEAR) |-> (!act_re && !oth_we && !in_chan.ready))
    else $error("access other than the clear sweep during clear");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bprs_pkg::ST_READ) |=> out_valid_r)
    else $error("pixel read gave no result");

  a_turn_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bprs_pkg::ST_TDONE && !cfg_hit) |=>
      (width_r == $past(height_r) && height_r == $past(width_r) &&
       active_r != $past(active_r)))
    else $error("turn did not swap dimensions and banks");
`endif

endmodule

@@ hw/rtl/bitmap_pixel_store_rotator_top.sv @@
// bitmap_pixel_store_rotator_top: two-bank frame store with pixel write/read and 90 degree turns.
// A write or out-of-image command loads its result on acceptance; an in-image read first passes
// the registered bank read port and READ; a turn walks one pixel per cycle over the bank ports
// in TURN, then TDONE swaps banks. Writes sustain one per cycle while results are taken; a read
// holds commands off until READ ends, a turn until TDONE. Reset (sync, rst_n low) and config
// writes to index 0-2 clear bank a, taking no command. Uses bprs_pkg, bprs_if, bprs_ctrl, bprs_bank.
`timescale 1ns / 1ps

module bitmap_pixel_store_rotator_top #(
  parameter int MAX_DIM = bprs_pkg::DEFAULT_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bprs_in_if.sink                          in_chan,
  bprs_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [bprs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bprs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  logic                       a_we, a_re, b_we, b_re;
  logic [AW-1:0]              a_waddr, a_raddr, b_waddr, b_raddr;
  logic [bprs_pkg::PIX_W-1:0] a_wdata, a_rdata, b_wdata, b_rdata;

  bprs_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .a_we      (a_we),
    .a_waddr   (a_waddr),
    .a_wdata   (a_wdata),
    .a_re      (a_re),
    .a_raddr   (a_raddr),
    .a_rdata   (a_rdata),
    .b_we      (b_we),
    .b_waddr   (b_waddr),
    .b_wdata   (b_wdata),
    .b_re      (b_re),
    .b_raddr   (b_raddr),
    .b_rdata   (b_rdata)
  );

  bprs_bank #(.MAX_DIM(MAX_DIM)) u_bank_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  bprs_bank #(.MAX_DIM(MAX_DIM)) u_bank_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

endmodule
